/* rtl/chta_pkg.sv */
// Shared types, field widths and codes for the clustered hash table.
// Used by every module of the block but chta_ram; depends on nothing.
`default_nettype none
package chta_pkg;

   localparam int DEF_CLUSTERS = 16384;
   localparam int DEF_WAYS     = 4;
   localparam int SCORE_OFFSET = 50000;
   localparam int ENTRY_W      = 128;   // data word low, tag word high

   localparam int REQ_TDATA_W  = 144;
   localparam int REQ_TUSER_W  = 2;
   localparam int RSP_TDATA_W  = 72;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [1:0] CMD_PROBE = 2'd0;
   localparam logic [1:0] CMD_STORE = 2'd1;
   localparam logic [1:0] CMD_EVAL  = 2'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_AGE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXACT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MATE  = 2'd2;

   localparam logic [15:0] MATE_RESET = 16'd49000;
   localparam logic [15:0] EVAL_NONE  = 16'h8000;
   localparam logic [15:0] EVAL_CLAMP = 16'h8001;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [63:0]        key;
      logic [7:0]         ply;
      logic [7:0]         depth;
      logic signed [16:0] score;
      logic [1:0]         bound_flag;
      logic [23:0]        move_code;
      logic               eval_valid;
      logic signed [15:0] static_eval;
      logic               pv_mark;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic [7:0]         out_depth;
      logic [23:0]        out_move;
      logic signed [16:0] out_score;
      logic [1:0]         out_flag;
      logic               out_eval_valid;
      logic signed [15:0] out_eval;
      logic               out_pv;
   } rsp_type;

   typedef struct packed {
      logic [4:0]  age;
      logic [1:0]  exact_code;
      logic [15:0] mate;
   } cfg_type;

endpackage
`default_nettype wire

/* rtl/chta_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module chta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

/* rtl/chta_cluster_eval.sv */
// Read-modify-write logic for one cluster row: match, victim choice, result.
// Depends on chta_pkg.
`default_nettype none
module chta_cluster_eval #(
   parameter int WAYS = chta_pkg::DEF_WAYS
) (
   input  wire logic [WAYS*chta_pkg::ENTRY_W-1:0] row,
   input  wire chta_pkg::req_type                 item,
   input  wire chta_pkg::cfg_type                 cfg,
   output      logic                              wr_en,
   output      logic [WAYS*chta_pkg::ENTRY_W-1:0] new_row,
   output      chta_pkg::rsp_type                 rsp
);
   import chta_pkg::*;

   localparam int WI = (WAYS > 1) ? $clog2(WAYS) : 1;

   logic [63:0]        d_w     [WAYS];
   logic [63:0]        t_w     [WAYS];
   logic [47:0]        fold_w  [WAYS];
   logic               match_w [WAYS];
   logic signed [10:0] val_w   [WAYS];
   logic [4:0]         rel_w   [WAYS];

   logic               any_m;
   logic [WI-1:0]      m_idx;
   logic [WI-1:0]      v_idx;
   logic [WI-1:0]      tgt;
   logic signed [10:0] worst;
   logic [63:0]        md;
   logic [63:0]        mt;
   logic [15:0]        ecode;
   logic [15:0]        ev;
   logic signed [17:0] psc;
   logic signed [17:0] mate18;
   logic signed [18:0] ssc;
   logic signed [18:0] mate19;
   logic               exact;
   logic               weak_st;
   logic               drop;
   logic [63:0]        nd;
   logic [47:0]        nfold;
   logic [63:0]        ntag;
   logic               wr_way;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         d_w[w]    = row[w*ENTRY_W +: 64];
         t_w[w]    = row[w*ENTRY_W+64 +: 64];
         fold_w[w] = d_w[w][47:0] ^ d_w[w][63:16] ^ {16'h0, d_w[w][63:32]}
                     ^ {32'h0, d_w[w][63:48]};
         match_w[w] = (d_w[w] != 64'd0) &&
                      (t_w[w][47:0] == (item.key[47:0] ^ fold_w[w]));
         rel_w[w]  = cfg.age - d_w[w][63:59];
         if (d_w[w] == 64'd0) begin
            val_w[w] = -11'sd1024;
         end else begin
            val_w[w] = $signed({3'b0, d_w[w][31:24]})
                       + ((d_w[w][58:57] == cfg.exact_code) ? 11'sd2 : 11'sd0)
                       - $signed({3'b0, rel_w[w], 3'b0});
         end
      end
   end

   // first matching way, and first way of lowest replacement value
   always_comb begin
      any_m = 1'b0;
      m_idx = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match_w[w]) begin
            any_m = 1'b1;
            m_idx = WI'(w);
         end
      end
      worst = 11'sd1023;
      v_idx = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (val_w[w] < worst) begin
            worst = val_w[w];
            v_idx = WI'(w);
         end
      end
   end

   always_comb begin
      md     = d_w[m_idx];
      mt     = t_w[m_idx];
      ecode  = !item.eval_valid ? EVAL_NONE :
               (item.static_eval == EVAL_NONE) ? EVAL_CLAMP : item.static_eval;
      exact  = item.bound_flag == cfg.exact_code;
      weak_st = any_m && !exact && ({2'b0, item.depth} + 10'd2 < {2'b0, md[31:24]});
      tgt    = any_m ? m_idx : v_idx;
      drop   = !any_m && (d_w[v_idx] != 64'd0) && !exact &&
               (worst > $signed({3'b0, item.depth}) + 11'sd2);

      mate18 = $signed({2'b0, cfg.mate});
      psc    = $signed({1'b0, md[56:40]}) - 18'sd50000;
      if (psc < -mate18) begin
         psc = psc + $signed({10'b0, item.ply});
      end
      if (psc > mate18) begin
         psc = psc - $signed({10'b0, item.ply});
      end

      mate19 = $signed({3'b0, cfg.mate});
      ssc    = 19'(item.score);
      if (ssc < -mate19) begin
         ssc = ssc - $signed({11'b0, item.ply});
      end
      if (ssc > mate19) begin
         ssc = ssc + $signed({11'b0, item.ply});
      end
      ssc    = ssc + 19'sd50000;
      nd     = {cfg.age, item.bound_flag, ssc[16:0], 7'b0, item.pv_mark,
                item.depth, item.move_code};
      nfold  = nd[47:0] ^ nd[63:16] ^ {16'h0, nd[63:32]} ^ {32'h0, nd[63:48]};
      ev     = item.eval_valid ? ecode : (any_m ? t_w[tgt][63:48] : EVAL_NONE);
      ntag   = {ev, item.key[47:0] ^ nfold};

      rsp     = '0;
      wr_way  = 1'b0;
      new_row = row;
      unique case (item.cmd)
         CMD_PROBE: begin
            if (any_m) begin
               rsp.hit            = 1'b1;
               rsp.out_depth      = md[31:24];
               rsp.out_move       = md[23:0];
               rsp.out_score      = psc[16:0];
               rsp.out_flag       = md[58:57];
               rsp.out_pv         = md[32];
               rsp.out_eval_valid = mt[63:48] != EVAL_NONE;
               rsp.out_eval       = (mt[63:48] != EVAL_NONE) ? mt[63:48] : 16'd0;
            end
         end
         CMD_EVAL: begin
            if (item.eval_valid && any_m) begin
               rsp.hit = 1'b1;
               wr_way  = 1'b1;
               new_row[m_idx*ENTRY_W+64 +: 64] = {ecode, mt[47:0]};
            end
         end
         CMD_STORE: begin
            if (weak_st) begin
               if (item.eval_valid) begin
                  wr_way = 1'b1;
                  new_row[m_idx*ENTRY_W+64 +: 64] = {ecode, mt[47:0]};
               end
            end else if (!drop) begin
               rsp.hit = 1'b1;
               wr_way  = 1'b1;
               new_row[tgt*ENTRY_W +: ENTRY_W] = {ntag, nd};
            end
         end
         default: ;
      endcase
      wr_en = wr_way;
   end
endmodule
`default_nettype wire

/* rtl/clustered_hash_table_with_aging.sv */
// Channel  Dir  Ports              Word contents
// req      in   req_t*             tuser cmd; tdata key..pv_mark
// rsp      out  rsp_t*             tdata hit..out_pv
// csr      in   csr_we/addr/wdata  age, exact flag code, mate threshold
//
// Each item goes through accept, key*CLUSTERS in two partial products of the
// 32-bit key halves, cluster row read, then evaluate and write back the row.
// After reset a clearing pass zeroes CLUSTERS rows, one per cycle; req
// is not taken meanwhile. A stalled rsp word holds the engine in the
// write-back step until it is taken.
`default_nettype none
module clustered_hash_table_with_aging #(
   parameter int CLUSTERS = chta_pkg::DEF_CLUSTERS,
   parameter int WAYS     = chta_pkg::DEF_WAYS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // key, ply, depth, score, bound_flag, move_code, eval_valid, static_eval,
   // pv_mark, zero pad
   input  wire logic [chta_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // cmd
   input  wire logic [chta_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // hit, out_depth, out_move, out_score, out_flag, out_eval_valid, out_eval,
   // out_pv, zero pad
   output      logic [chta_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire logic                               csr_we,
   input  wire logic [chta_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [chta_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import chta_pkg::*;

   localparam int CW    = $clog2(CLUSTERS);
   localparam int CB    = $clog2(CLUSTERS + 1);
   localparam int ROW_W = WAYS * ENTRY_W;

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_IDX  = 3'd3;
   localparam logic [2:0] ST_RD   = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CW-1:0]   clr_ff, clr_in;
   req_type         item_ff, item_in;
   cfg_type         cfg_ff, cfg_in;
   logic [31+CB:0]  plo_ff, plo_in;
   logic [31+CB:0]  phi_ff, phi_in;
   logic [32+CB:0]  psum;
   logic [CW-1:0]   idx_ff, idx_in;
   logic            rv_ff, rv_in;
   rsp_type         rsp_ff, rsp_in;

   logic            ram_we;
   logic [CW-1:0]   ram_waddr;
   logic [ROW_W-1:0] ram_wdata;
   logic [ROW_W-1:0] row;
   logic            ev_wr;
   logic [ROW_W-1:0] ev_row;
   rsp_type         ev_rsp;
   logic            done;

   chta_ram #(.WIDTH(ROW_W), .DEPTH(CLUSTERS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (state_ff == ST_IDX),
      .raddr (idx_in),
      .rdata (row)
   );

   chta_cluster_eval #(.WAYS(WAYS)) u_eval (
      .row     (row),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .wr_en   (ev_wr),
      .new_row (ev_row),
      .rsp     (ev_rsp)
   );

   assign req_tready = state_ff == ST_IDLE;
   assign done       = (state_ff == ST_RD) && (!rv_ff || rsp_tready);
   assign psum       = {1'b0, phi_ff} + (33+CB)'(plo_ff[31+CB:32]);

   always_comb begin
      item_in = item_ff;
      if (req_tvalid && req_tready) begin
         item_in.cmd         = req_tuser;
         item_in.key         = req_tdata[63:0];
         item_in.ply         = req_tdata[71:64];
         item_in.depth       = req_tdata[79:72];
         item_in.score       = req_tdata[96:80];
         item_in.bound_flag  = req_tdata[98:97];
         item_in.move_code   = req_tdata[122:99];
         item_in.eval_valid  = req_tdata[123];
         item_in.static_eval = req_tdata[139:124];
         item_in.pv_mark     = req_tdata[140];
      end
      plo_in = item_ff.key[31:0] * CB'(CLUSTERS);
      phi_in = item_ff.key[63:32] * CB'(CLUSTERS);
      idx_in = (state_ff == ST_IDX) ? psum[32 +: CW] : idx_ff;

      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_AGE:   cfg_in.age        = csr_wdata[4:0];
            CSR_EXACT: cfg_in.exact_code = csr_wdata[1:0];
            CSR_MATE:  cfg_in.mate       = csr_wdata;
            default: ;
         endcase
      end

      clr_in    = clr_ff;
      state_in  = state_ff;
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ev_row;
      unique case (state_ff)
         ST_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == CW'(CLUSTERS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: if (req_tvalid) state_in = ST_MUL;
         ST_MUL:  state_in = ST_IDX;
         ST_IDX:  state_in = ST_RD;
         ST_RD: begin
            if (done) begin
               ram_we   = ev_wr;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_in = done ? ev_rsp : rsp_ff;
      rv_in  = done ? 1'b1 : (rsp_tready ? 1'b0 : rv_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
         cfg_ff   <= '{age: 5'd0, exact_code: 2'd0, mate: MATE_RESET};
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
         cfg_ff   <= cfg_in;
      end
      item_ff <= item_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {2'b0, rsp_ff.out_pv, rsp_ff.out_eval, rsp_ff.out_eval_valid,
                        rsp_ff.out_flag, rsp_ff.out_score, rsp_ff.out_move,
                        rsp_ff.out_depth, rsp_ff.hit};

`ifndef ASSERT_OFF
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLR) |-> !req_tready)
      else $error("req ready during clearing pass");
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLR || done))
      else $error("row write outside clear or write-back");
   a_accept_flow: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_MUL))
      else $error("accepted word did not start the lookup");
   a_rsp_only_after_rd: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> ($past(state_ff) == ST_RD))
      else $error("rsp word raised outside write-back");
`endif
endmodule
`default_nettype wire

/* tb/sv/tb_clustered_hash_table_with_aging.sv */
// Self-checking testbench for clustered_hash_table_with_aging: directed table, then random
// phases under several register settings, checked against a behavioral table predictor.
// Depends on rtl/chta_pkg.sv and the RTL top level only.
`timescale 1ns / 100ps
module tb_clustered_hash_table_with_aging;
   import chta_pkg::*;

   localparam int LIMIT_CYCLES = 2000000;
   localparam int RANDOM_PER_PHASE = 120;
   localparam logic [1:0] CMD_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   clustered_hash_table_with_aging i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic [63:0] slot_data [int];
   logic [63:0] slot_tag [int];
   logic [4:0]  age_now = 5'd0;
   logic [1:0]  exact_now = 2'd0;
   logic [15:0] mate_now = MATE_RESET;

   rsp_type expected_rsp[$];
   int mismatches = 0;
   int cycles = 0;
   int items_sent = 0;
   bit quiet = 1'b0;
   int hold_left = 0;
   logic [63:0] key_pool [24];

   function automatic logic [63:0] rd_data(int s);
      return slot_data.exists(s) ? slot_data[s] : 64'd0;
   endfunction

   function automatic logic [63:0] rd_tag(int s);
      return slot_tag.exists(s) ? slot_tag[s] : 64'd0;
   endfunction

   function automatic logic [47:0] key_tag(logic [63:0] key, logic [63:0] d);
      logic [63:0] fold;
      fold = d ^ (d >> 16) ^ (d >> 32) ^ (d >> 48);
      return key[47:0] ^ fold[47:0];
   endfunction

   function automatic bit slot_matches(int s, logic [63:0] key);
      logic [63:0] d;
      logic [63:0] t;
      d = rd_data(s);
      t = rd_tag(s);
      return d != 0 && t[47:0] == key_tag(key, d);
   endfunction

   function automatic logic [15:0] eval_word(req_type r);
      if (!r.eval_valid) return EVAL_NONE;
      if (r.static_eval == EVAL_NONE) return EVAL_CLAMP;
      return r.static_eval;
   endfunction

   function automatic int replace_value(logic [63:0] d);
      int v;
      logic [4:0] rel;
      if (d == 0) return -1000000;
      v = int'(d[31:24]);
      if (d[58:57] == exact_now) v += 2;
      rel = age_now - d[63:59];
      return v - 8 * int'(rel);
   endfunction

   function automatic void put_eval(int s, logic [15:0] code);
      logic [63:0] t;
      t = rd_tag(s);
      slot_tag[s] = {code, t[47:0]};
   endfunction

   // Runs one command against the table copy and returns the response word.
   function automatic rsp_type table_access(req_type r);
      rsp_type o;
      int base, s, sc, dep, worst, victim, mate;
      logic [63:0] d, vdata, t;
      logic [15:0] ev;
      logic [16:0] sfield;
      bit same, exact;
      o = '0;
      base = int'(r.key[63:50]) * 4;
      mate = int'(mate_now);
      case (r.cmd)
         CMD_PROBE: begin
            for (int w = 0; w < 4; w++) begin
               s = base + w;
               if (slot_matches(s, r.key)) begin
                  d = rd_data(s);
                  t = rd_tag(s);
                  ev = t[63:48];
                  sc = int'(d[56:40]) - SCORE_OFFSET;
                  if (sc < -mate) sc += int'(r.ply);
                  if (sc > mate) sc -= int'(r.ply);
                  o.hit = 1'b1;
                  o.out_depth = d[31:24];
                  o.out_move = d[23:0];
                  o.out_score = sc[16:0];
                  o.out_flag = d[58:57];
                  if (ev != EVAL_NONE) begin
                     o.out_eval_valid = 1'b1;
                     o.out_eval = ev;
                  end
                  o.out_pv = d[32];
                  return o;
               end
            end
         end
         CMD_EVAL: begin
            if (!r.eval_valid) return o;
            for (int w = 0; w < 4; w++) begin
               if (slot_matches(base + w, r.key)) begin
                  put_eval(base + w, eval_word(r));
                  o.hit = 1'b1;
                  return o;
               end
            end
         end
         CMD_STORE: begin
            dep = int'(r.depth);
            sc = int'(r.score);
            exact = r.bound_flag == exact_now;
            victim = base;
            vdata = 0;
            worst = 1000000;
            same = 1'b0;
            for (int w = 0; w < 4; w++) begin
               s = base + w;
               d = rd_data(s);
               if (slot_matches(s, r.key)) begin
                  if (!exact && dep < int'(d[31:24]) - 2) begin
                     if (r.eval_valid) put_eval(s, eval_word(r));
                     return o;
                  end
                  victim = s;
                  vdata = d;
                  same = 1'b1;
                  break;
               end
               if (replace_value(d) < worst) begin
                  worst = replace_value(d);
                  victim = s;
                  vdata = d;
               end
            end
            // weak store into a full cluster is dropped
            if (!same && vdata != 0 && !exact && worst > dep + 2) return o;
            if (sc < -mate) sc -= int'(r.ply);
            if (sc > mate) sc += int'(r.ply);
            sc += SCORE_OFFSET;
            sfield = sc[16:0];
            d = {age_now, r.bound_flag, sfield, 7'd0, r.pv_mark, r.depth, r.move_code};
            t = rd_tag(victim);
            if (r.eval_valid) ev = eval_word(r);
            else if (same) ev = t[63:48];
            else ev = EVAL_NONE;
            slot_data[victim] = d;
            slot_tag[victim] = {ev, key_tag(r.key, d)};
            o.hit = 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic write_reg(logic [CSR_ADDR_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AGE:   age_now = val[4:0];
         CSR_EXACT: exact_now = val[1:0];
         default:   mate_now = val;
      endcase
   endtask

   task automatic drain_and_set(logic [4:0] age, logic [1:0] ex, logic [15:0] mate);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (8) @(posedge clock);
      write_reg(CSR_AGE, 16'(age));
      write_reg(CSR_EXACT, 16'(ex));
      write_reg(CSR_MATE, mate);
   endtask

   task automatic send_word(req_type r, bit fixed, rsp_type fx);
      rsp_type p;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.cmd;
      req_tdata <= {3'd0, r.pv_mark, r.static_eval, r.eval_valid, r.move_code,
                    r.bound_flag, r.score, r.depth, r.ply, r.key};
      do @(posedge clock); while (!req_tready);
      p = table_access(r);
      expected_rsp.push_back(fixed ? fx : p);
      items_sent++;
   endtask

   function automatic req_type random_word();
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.cmd = pick < 40 ? CMD_PROBE : pick < 82 ? CMD_STORE : pick < 96 ? CMD_EVAL : CMD_NONE;
      r.key = $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : key_pool[$urandom_range(0, 23)];
      r.ply = 8'($urandom);
      r.depth = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 20));
      pick = $urandom_range(0, 9);
      if (pick < 3) r.score = 17'($urandom_range(0, 2000) + 48000);
      else if (pick < 6) r.score = 17'(-$urandom_range(48000, 50000));
      else if (pick < 7) r.score = 17'($urandom);
      else r.score = 17'($urandom_range(0, 100000) - 50000);
      r.bound_flag = 2'($urandom);
      r.move_code = 24'($urandom);
      r.eval_valid = $urandom_range(0, 3) != 0;
      r.static_eval = $urandom_range(0, 15) == 0 ? EVAL_NONE : 16'($urandom);
      r.pv_mark = 1'($urandom);
      return r;
   endfunction

   // result side: random stalls, plus one long hold-off while requests keep coming
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (burst > 0) begin
            rsp_tready <= 1'b0;
            burst--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            burst = $urandom_range(0, 11);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tdata[0];
         got.out_depth = rsp_tdata[8:1];
         got.out_move = rsp_tdata[32:9];
         got.out_score = rsp_tdata[49:33];
         got.out_flag = rsp_tdata[51:50];
         got.out_eval_valid = rsp_tdata[52];
         got.out_eval = rsp_tdata[68:53];
         got.out_pv = rsp_tdata[69];
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp word %h", rsp_tdata);
         end else begin
            want = expected_rsp.pop_front();
            if (got.hit !== want.hit || got.out_depth !== want.out_depth ||
                got.out_move !== want.out_move || got.out_score !== want.out_score ||
                got.out_flag !== want.out_flag || got.out_eval_valid !== want.out_eval_valid ||
                got.out_eval !== want.out_eval || got.out_pv !== want.out_pv) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_type dir [20];
      rsp_type fixed_rsp [20];
      bit has_fixed [20];
      req_type r;
      rsp_type zero_rsp, store_ok;
      logic [63:0] ka, kc;

      for (int i = 0; i < 24; i++) begin
         kc = {$urandom, $urandom};
         kc[63:50] = i % 3 == 0 ? 14'd0 : i % 3 == 1 ? 14'h3fff : 14'd5;
         key_pool[i] = kc;
      end
      ka = key_pool[1];
      zero_rsp = '0;
      store_ok = '0;
      store_ok.hit = 1'b1;

      for (int i = 0; i < 20; i++) begin
         dir[i] = '0;
         dir[i].key = ka;
         has_fixed[i] = 1'b0;
         fixed_rsp[i] = zero_rsp;
      end
      has_fixed[0] = 1'b1;                              // probe on empty table
      dir[1].cmd = CMD_NONE; has_fixed[1] = 1'b1;
      dir[2].cmd = CMD_EVAL; has_fixed[2] = 1'b1;       // eval update without eval
      dir[3] = '{CMD_STORE, ka, 8'd255, 8'd255, 17'sd50000, 2'd0, 24'hffffff,
                 1'b1, 16'h8000, 1'b1};
      has_fixed[3] = 1'b1; fixed_rsp[3] = store_ok;
      dir[4].ply = 8'd255;
      dir[5] = '{CMD_STORE, ka, 8'd0, 8'd0, 17'sd10, 2'd1, 24'd1, 1'b1, 16'h7fff, 1'b0};
      dir[7] = '{CMD_EVAL, ka, 8'd0, 8'd0, 17'sd0, 2'd0, 24'd0, 1'b1, 16'h1234, 1'b0};
      dir[9] = '{CMD_STORE, ka, 8'd3, 8'd10, -17'sd50000, 2'd0, 24'h00abcd,
                 1'b0, 16'h0, 1'b0};
      dir[10].ply = 8'd7;
      for (int i = 11; i < 16; i++)
         dir[i] = '{CMD_STORE, key_pool[4 + 3 * (i - 11)], 8'd0, 8'(i - 10), 17'sd100,
                    2'd1, 24'(i), 1'b0, 16'h0, 1'b1};
      dir[15].depth = 8'd0;                             // depth-0 store into full cluster
      dir[16].key = key_pool[16];
      dir[17] = '{CMD_STORE, 64'd0, 8'd0, 8'd0, -17'sd50000, 2'd0, 24'd0,
                  1'b0, 16'h0, 1'b0};                   // data word comes out all zero
      dir[18].key = 64'd0;
      dir[19].key = '1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_reg(CSR_AGE, 16'd0);
      write_reg(CSR_EXACT, 16'd0);
      write_reg(CSR_MATE, MATE_RESET);
      for (int i = 0; i < 20; i++) send_word(dir[i], has_fixed[i], fixed_rsp[i]);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: drain_and_set(5'd31, 2'd3, 16'd0);
            1: drain_and_set(5'($urandom), 2'd1, 16'd50000);
            2: drain_and_set(5'd3, 2'd2, 16'($urandom_range(0, 50000)));
            default: drain_and_set(5'd7, 2'd0, MATE_RESET);
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (ph == 1 && n == 10) hold_left = 400;
            if (ph == 3 && n == RANDOM_PER_PHASE / 2) quiet = 1'b1;
            r = random_word();
            send_word(r, 1'b0, zero_rsp);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (expected_rsp.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
